>>> rtl/cnlc_pkg.sv
// Shared types, constants and microcode for the card number Luhn classifier.
package cnlc_pkg;

  localparam int CARD_W       = 54;
  localparam int DIGITS       = 17;
  localparam int BCD_W        = 4 * DIGITS;
  localparam int BITS_PER_OP  = 3;
  localparam int CNT_W        = 5;
  localparam int COUNT_W      = 5;
  localparam int CLASS_W      = 2;

  localparam logic [CNT_W-1:0] DABBLE_LAST = CNT_W'(CARD_W / BITS_PER_OP - 1);
  localparam logic [CNT_W-1:0] DIGIT_LAST  = CNT_W'(DIGITS - 1);

  localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

  localparam logic [3:0] LEAD_FOUR  = 4'd4;
  localparam logic [3:0] LEAD_THREE = 4'd3;
  localparam logic [3:0] LEAD_FIVE  = 4'd5;
  localparam logic [3:0] NEXT_FOUR  = 4'd4;
  localparam logic [3:0] NEXT_SEVEN = 4'd7;
  localparam logic [3:0] NEXT_ONE   = 4'd1;
  localparam logic [3:0] NEXT_FIVE  = 4'd5;

  localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_LEAD4 = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_3X    = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_5X    = 2'd3;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_DABBLE = 2'd1;
  localparam op_t OP_DIGIT  = 2'd2;
  localparam op_t OP_DONE   = 2'd3;

  typedef logic [1:0] cond_t;
  localparam cond_t COND_NONE  = 2'd0;
  localparam cond_t COND_START = 2'd1;
  localparam cond_t COND_LOOP  = 2'd2;

  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE   = 2'd0;
  localparam step_t STEP_DABBLE = 2'd1;
  localparam step_t STEP_DIGIT  = 2'd2;
  localparam step_t STEP_DONE   = 2'd3;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    step_t            target;
    logic [CNT_W-1:0] limit;
  } uword_t;

  typedef struct packed {
    op_t              op;
    logic             load;
    logic [CNT_W-1:0] idx;
  } ctrl_t;

  function automatic uword_t ucode_rom(input step_t addr);
    uword_t w;
    case (addr)
      STEP_IDLE:   w = '{OP_LOAD,   COND_START, STEP_IDLE,   '0};
      STEP_DABBLE: w = '{OP_DABBLE, COND_LOOP,  STEP_DABBLE, DABBLE_LAST};
      STEP_DIGIT:  w = '{OP_DIGIT,  COND_LOOP,  STEP_DIGIT,  DIGIT_LAST};
      STEP_DONE:   w = '{OP_DONE,   COND_NONE,  STEP_IDLE,   '0};
      default:     w = '{OP_DONE,   COND_NONE,  STEP_IDLE,   '0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/cnlc_useq.sv
// Microcode sequencer: step counter, loop counter and control word decode.
module cnlc_useq import cnlc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output ctrl_t ctrl
);

  step_t            step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  uword_t           w;

  assign w = ucode_rom(step_r);

  always_comb begin
    step_nxt = step_r + 2'd1;
    cnt_nxt  = '0;
    case (w.cond)
      COND_START: begin
        if (!start) begin
          step_nxt = w.target;
        end
      end
      COND_LOOP: begin
        if (cnt_r != w.limit) begin
          step_nxt = w.target;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      COND_NONE: begin
        step_nxt = w.target;
      end
      default: begin
        step_nxt = STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy      = (step_r != STEP_IDLE);
  assign ctrl.op   = w.op;
  assign ctrl.load = (w.op == OP_LOAD) && start;
  assign ctrl.idx  = cnt_r;

endmodule

>>> rtl/cnlc_dpath.sv
// Datapath: binary to decimal conversion, Luhn sum, digit count and classification.
module cnlc_dpath import cnlc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  input  logic [CARD_W-1:0]  in_card_number,
  output logic               out_valid,
  output logic [CLASS_W-1:0] out_card_class,
  output logic               out_checksum_ok,
  output logic [COUNT_W-1:0] out_digit_count
);

  logic [CARD_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [3:0]         sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [3:0]         lead_r, lead_nxt;
  logic [3:0]         next_r, next_nxt;
  logic [3:0]         prev_r, prev_nxt;
  logic               valid_r, valid_nxt;
  logic [CLASS_W-1:0] class_r, class_nxt;
  logic               ok_r, ok_nxt;
  logic [COUNT_W-1:0] dcount_r, dcount_nxt;

  logic [3:0] dig;
  logic [3:0] addend;
  logic [4:0] acc;
  logic       sum_ok;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] v, input logic b);
    logic [BCD_W-1:0] adj;
    adj = v;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = v[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  assign dig    = bcd_r[3:0];
  assign addend = ctrl.idx[0] ? ((dig < 4'd5) ? 4'(dig << 1) : 4'((dig << 1) - 4'd9)) : dig;
  assign acc    = 5'(sum_r) + 5'(addend);
  assign sum_ok = (sum_r == 4'd0);

  always_comb begin
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    lead_nxt   = lead_r;
    next_nxt   = next_r;
    prev_nxt   = prev_r;
    valid_nxt  = 1'b0;
    class_nxt  = class_r;
    ok_nxt     = ok_r;
    dcount_nxt = dcount_r;
    case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.load) begin
          bin_nxt   = in_card_number;
          bcd_nxt   = '0;
          sum_nxt   = '0;
          count_nxt = '0;
          lead_nxt  = '0;
          next_nxt  = '0;
          prev_nxt  = '0;
        end
      end
      OP_DABBLE: begin
        bcd_nxt = dabble(dabble(dabble(bcd_r, bin_r[CARD_W-1]), bin_r[CARD_W-2]),
                         bin_r[CARD_W-3]);
        bin_nxt = {bin_r[CARD_W-BITS_PER_OP-1:0], {BITS_PER_OP{1'b0}}};
      end
      OP_DIGIT: begin
        bcd_nxt  = {4'd0, bcd_r[BCD_W-1:4]};
        sum_nxt  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
        prev_nxt = dig;
        if (dig != 4'd0) begin
          count_nxt = COUNT_W'(ctrl.idx + CNT_W'(1));
          lead_nxt  = dig;
          next_nxt  = prev_r;
        end
      end
      OP_DONE: begin
        valid_nxt  = 1'b1;
        ok_nxt     = sum_ok;
        dcount_nxt = count_r;
        class_nxt  = CLASS_NONE;
        if (sum_ok) begin
          if ((count_r == LEN_13 || count_r == LEN_16) && lead_r == LEAD_FOUR) begin
            class_nxt = CLASS_LEAD4;
          end else if (count_r == LEN_15 && lead_r == LEAD_THREE &&
                       (next_r == NEXT_FOUR || next_r == NEXT_SEVEN)) begin
            class_nxt = CLASS_3X;
          end else if (count_r == LEN_16 && lead_r == LEAD_FIVE &&
                       next_r >= NEXT_ONE && next_r <= NEXT_FIVE) begin
            class_nxt = CLASS_5X;
          end
        end
      end
      default: begin
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r    <= bin_nxt;
    bcd_r    <= bcd_nxt;
    sum_r    <= sum_nxt;
    count_r  <= count_nxt;
    lead_r   <= lead_nxt;
    next_r   <= next_nxt;
    prev_r   <= prev_nxt;
    class_r  <= class_nxt;
    ok_r     <= ok_nxt;
    dcount_r <= dcount_nxt;
  end

  assign out_valid       = valid_r;
  assign out_card_class  = class_r;
  assign out_checksum_ok = ok_r;
  assign out_digit_count = dcount_r;

endmodule

>>> rtl/card_number_luhn_classifier_core.sv
// Top level of the card number Luhn classifier: sequencer, datapath and checks.
//
// Channel   Direction  Handshake          Ports
// input     in         start, busy        in_card_number
// result    out        out_valid strobe   out_card_class, out_checksum_ok, out_digit_count
//
// An item is taken when start is high and busy is low. It then passes through the
// binary to decimal converter (three bits per cycle), a walk over the decimal
// digits and a classifying step; out_valid, registered from that step, then pulses
// for one cycle, and busy is already low in that cycle.
// Reset is synchronous and active low and returns the sequencer to idle.
// The receiver cannot stall, so nothing waits on the result side.
module card_number_luhn_classifier_core import cnlc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CARD_W-1:0]  in_card_number,
  output logic               out_valid,
  output logic [CLASS_W-1:0] out_card_class,
  output logic               out_checksum_ok,
  output logic [COUNT_W-1:0] out_digit_count
);

  ctrl_t ctrl;

  cnlc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  cnlc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .in_card_number  (in_card_number),
    .out_valid       (out_valid),
    .out_card_class  (out_card_class),
    .out_checksum_ok (out_checksum_ok),
    .out_digit_count (out_digit_count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy did not rise after an accepted item");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_class_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_checksum_ok) |-> (out_card_class == CLASS_NONE))
    else $error("class given to a number with a bad checksum");

endmodule
